FILE: rtl/hhlf_pkg.sv
// Shared constants and character helpers for the HTTP header length framer.
`timescale 1ns / 1ps

package hhlf_pkg;

	localparam int COUNT_BITS_DEFAULT = 32;
	localparam int VALUE_BITS = 31;
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};
	localparam logic [3:0] NAME_LEN = 4'd14;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	function automatic logic is_ws(input logic [7:0] b);
		return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'd32) : b;
	endfunction

	// Lower-case spelling of the header name that carries the body length.
	function automatic logic [7:0] name_char_at(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/http_header_length_framer.sv
// HTTP request framer: finds the header end and the Content-Length value, counts request bytes.
`timescale 1ns / 1ps

// The block takes one request byte per clock cycle and returns one result item per byte,
// registered when the byte is accepted. All per-byte work (header terminator search, header
// name match, decimal value parse, byte count and target compare) sits between the stored
// state and a single result register, so items flow back to back at one per cycle. The input
// is stalled only while a result sits in the result register and the output side stalls it.
// Raising first_byte with a byte starts a new request; the byte count and target are
// COUNT_BITS wide and saturate, which also sets length_overflow.
module http_header_length_framer #(
	parameter int COUNT_BITS = hhlf_pkg::COUNT_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        header_end,
	output logic        request_done,
	output logic        length_found,
	output logic [30:0] body_length,
	output logic [31:0] bytes_seen,
	output logic        length_overflow
);

	localparam int VB = hhlf_pkg::VALUE_BITS;
	localparam int SUM_BITS = ((COUNT_BITS > VB) ? COUNT_BITS : VB) + 1;
	localparam int EXT_BITS = COUNT_BITS + 32;
	localparam int DIG_BITS = VB + 4;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		PH_FIELD_LEAD,
		PH_FIELD_NAME,
		PH_FIELD_TRAIL,
		PH_VALUE_LEAD,
		PH_VALUE_SIGN,
		PH_VALUE_DIGITS,
		PH_VALUE_DONE,
		PH_LINE_SKIP
	} phase_t;

	// Stored request state.
	logic [1:0]            term_q;
	logic                  header_seen_q;
	phase_t                phase_q;
	logic [3:0]            name_pos_q;
	logic                  name_match_q;
	logic                  neg_q;
	logic [VB-1:0]         acc_q;
	logic [VB-1:0]         len_q;
	logic                  len_seen_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] target_q;
	logic                  finished_q;
	logic                  ovf_q;

	// Result register.
	logic                  out_valid_q;
	logic                  header_end_q;
	logic                  request_done_q;
	logic                  length_found_q;
	logic [30:0]           body_length_q;
	logic [31:0]           bytes_seen_q;
	logic                  length_overflow_q;

	// State as seen by this byte, after an optional restart.
	logic [1:0]            c_term;
	logic                  c_hs;
	phase_t                c_phase;
	logic [3:0]            c_pos;
	logic                  c_match;
	logic                  c_neg;
	logic [VB-1:0]         c_acc;
	logic [VB-1:0]         c_len;
	logic                  c_len_seen;
	logic [COUNT_BITS-1:0] c_count;
	logic [COUNT_BITS-1:0] c_target;
	logic                  c_fin;
	logic                  c_ovf;

	// Next state.
	logic [1:0]            n_term;
	logic                  n_hs;
	phase_t                n_phase;
	logic [3:0]            n_pos;
	logic                  n_match;
	logic                  n_neg;
	logic [VB-1:0]         n_acc;
	logic [VB-1:0]         n_len;
	logic                  n_len_seen;
	logic [COUNT_BITS-1:0] n_count;
	logic [COUNT_BITS-1:0] n_target;
	logic                  n_fin;
	logic                  n_ovf;

	logic                  hend;
	logic                  complete;
	logic                  sp;
	logic                  name_hit;
	logic [DIG_BITS-1:0]   dig_sum;
	logic                  dig_big;
	logic [VB-1:0]         dig_val;
	logic [SUM_BITS-1:0]   tgt_sum;
	logic                  tgt_sat;
	logic [EXT_BITS-1:0]   count_ext;
	logic [31:0]           bytes_out;
	logic                  take;

	assign take     = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall;

	always_comb begin
		c_term     = first_byte ? 2'b00 : term_q;
		c_hs       = first_byte ? 1'b0 : header_seen_q;
		c_phase    = first_byte ? PH_FIELD_LEAD : phase_q;
		c_pos      = first_byte ? 4'd0 : name_pos_q;
		c_match    = first_byte ? 1'b1 : name_match_q;
		c_neg      = first_byte ? 1'b0 : neg_q;
		c_acc      = first_byte ? '0 : acc_q;
		c_len      = first_byte ? '0 : len_q;
		c_len_seen = first_byte ? 1'b0 : len_seen_q;
		c_count    = first_byte ? '0 : count_q;
		c_target   = first_byte ? COUNT_MAX : target_q;
		c_fin      = first_byte ? 1'b0 : finished_q;
		c_ovf      = first_byte ? 1'b0 : ovf_q;

		n_term     = c_term;
		n_hs       = c_hs;
		n_phase    = c_phase;
		n_pos      = c_pos;
		n_match    = c_match;
		n_neg      = c_neg;
		n_acc      = c_acc;
		n_len      = c_len;
		n_len_seen = c_len_seen;
		n_target   = c_target;
		n_fin      = c_fin;
		n_ovf      = c_ovf;
		hend       = 1'b0;
		complete   = 1'b0;
		tgt_sum    = '0;
		tgt_sat    = 1'b0;

		sp       = hhlf_pkg::is_ws(data_byte);
		name_hit = (c_pos < hhlf_pkg::NAME_LEN) &&
			(hhlf_pkg::to_lower(data_byte) == hhlf_pkg::name_char_at(c_pos));

		// Multiply by ten as two shifts; a digit's value is its low nibble.
		dig_sum = DIG_BITS'({c_acc, 3'b000}) + DIG_BITS'({c_acc, 1'b0}) +
			DIG_BITS'(data_byte[3:0]);
		dig_big = dig_sum > DIG_BITS'(hhlf_pkg::VALUE_MAX);
		dig_val = dig_big ? hhlf_pkg::VALUE_MAX : dig_sum[VB-1:0];

		if (c_count == COUNT_MAX) begin
			n_count = c_count;
			n_ovf   = 1'b1;
		end else begin
			n_count = c_count + COUNT_BITS'(1);
		end

		if (!c_hs) begin
			if ((data_byte == hhlf_pkg::CH_LF) && c_term[0]) begin
				// A CR LF closes the line; a matching line commits its value.
				if ((c_phase == PH_VALUE_LEAD) || (c_phase == PH_VALUE_SIGN) ||
					(c_phase == PH_VALUE_DIGITS) || (c_phase == PH_VALUE_DONE)) begin
					n_len      = c_neg ? '0 : c_acc;
					n_len_seen = 1'b1;
				end
				n_phase = PH_FIELD_LEAD;
				n_pos   = 4'd0;
				n_match = 1'b1;
				n_neg   = 1'b0;
				n_acc   = '0;
			end else begin
				case (c_phase)
					PH_FIELD_LEAD: begin
						if (!sp) begin
							if (data_byte == hhlf_pkg::CH_COLON) begin
								n_phase = PH_LINE_SKIP;
							end else begin
								n_phase = PH_FIELD_NAME;
								if (name_hit) n_pos = c_pos + 4'd1;
								else n_match = 1'b0;
							end
						end
					end
					PH_FIELD_NAME, PH_FIELD_TRAIL: begin
						if (data_byte == hhlf_pkg::CH_COLON) begin
							n_phase = (c_match && (c_pos == hhlf_pkg::NAME_LEN)) ?
								PH_VALUE_LEAD : PH_LINE_SKIP;
						end else if (sp) begin
							n_phase = PH_FIELD_TRAIL;
						end else if (c_phase == PH_FIELD_TRAIL) begin
							// Text after trailing whitespace spoils the name.
							n_match = 1'b0;
							n_phase = PH_FIELD_NAME;
						end else if (name_hit) begin
							n_pos = c_pos + 4'd1;
						end else begin
							n_match = 1'b0;
						end
					end
					PH_VALUE_LEAD, PH_VALUE_SIGN, PH_VALUE_DIGITS: begin
						if (hhlf_pkg::is_digit(data_byte)) begin
							n_acc   = dig_val;
							n_phase = PH_VALUE_DIGITS;
							if (dig_big && !c_neg) n_ovf = 1'b1;
						end else if (c_phase != PH_VALUE_LEAD) begin
							n_phase = PH_VALUE_DONE;
						end else if (sp) begin
							n_phase = c_phase;
						end else if (data_byte == hhlf_pkg::CH_PLUS) begin
							n_phase = PH_VALUE_SIGN;
						end else if (data_byte == hhlf_pkg::CH_MINUS) begin
							n_neg   = 1'b1;
							n_phase = PH_VALUE_SIGN;
						end else begin
							n_phase = PH_VALUE_DONE;
						end
					end
					default: begin
						n_phase = c_phase;
					end
				endcase
			end

			if (data_byte == hhlf_pkg::CH_CR) begin
				n_term = (c_term == 2'd2) ? 2'd3 : 2'd1;
			end else if (data_byte == hhlf_pkg::CH_LF) begin
				complete = (c_term == 2'd3);
				n_term   = (c_term == 2'd1) ? 2'd2 : 2'd0;
			end else begin
				n_term = 2'd0;
			end

			if (complete) begin
				n_hs   = 1'b1;
				hend   = 1'b1;
				n_term = 2'd0;
				if (n_len_seen) begin
					tgt_sum  = SUM_BITS'(n_count) + SUM_BITS'(n_len);
					tgt_sat  = tgt_sum > SUM_BITS'(COUNT_MAX);
					n_target = tgt_sat ? COUNT_MAX : tgt_sum[COUNT_BITS-1:0];
					if (tgt_sat) n_ovf = 1'b1;
					// The count already meets the new target only for a zero length,
					// or when both sit at the saturation value.
					if ((n_len == '0) || (tgt_sat && (n_count == COUNT_MAX))) n_fin = 1'b1;
				end else begin
					n_fin = 1'b1;
				end
			end
		end else if (c_len_seen && (n_count >= c_target)) begin
			n_fin = 1'b1;
		end

		count_ext = EXT_BITS'(n_count);
		bytes_out = (count_ext > EXT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : count_ext[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q            <= 2'b00;
			header_seen_q     <= 1'b0;
			phase_q           <= PH_FIELD_LEAD;
			name_pos_q        <= 4'd0;
			name_match_q      <= 1'b1;
			neg_q             <= 1'b0;
			acc_q             <= '0;
			len_q             <= '0;
			len_seen_q        <= 1'b0;
			count_q           <= '0;
			target_q          <= COUNT_MAX;
			finished_q        <= 1'b0;
			ovf_q             <= 1'b0;
			out_valid_q       <= 1'b0;
			header_end_q      <= 1'b0;
			request_done_q    <= 1'b0;
			length_found_q    <= 1'b0;
			body_length_q     <= '0;
			bytes_seen_q      <= '0;
			length_overflow_q <= 1'b0;
		end else begin
			if (take) begin
				term_q            <= n_term;
				header_seen_q     <= n_hs;
				phase_q           <= n_phase;
				name_pos_q        <= n_pos;
				name_match_q      <= n_match;
				neg_q             <= n_neg;
				acc_q             <= n_acc;
				len_q             <= n_len;
				len_seen_q        <= n_len_seen;
				count_q           <= n_count;
				target_q          <= n_target;
				finished_q        <= n_fin;
				ovf_q             <= n_ovf;
				out_valid_q       <= 1'b1;
				header_end_q      <= hend;
				request_done_q    <= n_fin;
				length_found_q    <= n_len_seen;
				body_length_q     <= n_len;
				bytes_seen_q      <= bytes_out;
				length_overflow_q <= n_ovf;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign header_end      = header_end_q;
	assign request_done    = request_done_q;
	assign length_found    = length_found_q;
	assign body_length     = body_length_q;
	assign bytes_seen      = bytes_seen_q;
	assign length_overflow = length_overflow_q;

	// A finished request stays finished until a new request starts.
	assert property (@(posedge clk) disable iff (!arst_n)
		finished_q && !(take && first_byte) |=> finished_q)
		else $error("request_done dropped without a new request");

	// A header end with no length found completes the request at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_end && !length_found |-> request_done)
		else $error("header end without length did not finish the request");

	// No length is reported before a length line has been committed.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !length_found |-> (body_length == '0))
		else $error("body length nonzero without a length line");

	// The input is held back only while a result is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty result register");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the HTTP header length framer.
`timescale 1ns / 1ps

module tb_top;

	localparam int IDLE_LIMIT = 4000;
	localparam logic [32:0] COUNT_TOP = 33'h0_FFFF_FFFF;
	localparam logic [8*14-1:0] LEN_NAME = "content-length";

	typedef enum logic [2:0] {
		PH_LEAD, PH_NAME, PH_TRAIL, PH_VLEAD, PH_VSIGN, PH_VDIGITS, PH_VDONE, PH_SKIP
	} line_phase_t;

	typedef struct {
		logic [7:0] data;
		logic       first;
	} byte_item_t;

	typedef struct {
		logic        hend;
		logic        done;
		logic        found;
		logic [30:0] len;
		logic [31:0] seen;
		logic        ovf;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        first_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        header_end;
	logic        request_done;
	logic        length_found;
	logic [30:0] body_length;
	logic [31:0] bytes_seen;
	logic        length_overflow;

	http_header_length_framer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .first_byte(first_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.header_end(header_end), .request_done(request_done),
		.length_found(length_found), .body_length(body_length),
		.bytes_seen(bytes_seen), .length_overflow(length_overflow)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	byte_item_t    pending_bytes[$];
	frame_result_t expected_frames[$];
	logic          mark_first = 1'b0;
	logic          in_taken = 1'b0;
	int            idle_cycles = 0;
	int            mismatches = 0;
	int            bytes_in = 0;
	int            requests_in = 0;
	int            results_checked = 0;
	int            header_ends = 0;
	int            done_results = 0;
	int            ovf_results = 0;

	// Predictor state for the request currently being framed.
	logic [1:0]  crlf_prog;
	logic        hdr_seen;
	line_phase_t phase;
	logic [3:0]  name_pos;
	logic        name_ok;
	logic        val_neg;
	logic [30:0] val_acc;
	logic [30:0] len_val;
	logic        len_seen;
	logic [32:0] byte_cnt;
	logic [32:0] target_cnt;
	logic        req_done;
	logic        ovf_seen;

	function automatic logic space_char(input logic [7:0] b);
		return (b >= 8'h09 && b <= 8'h0D) || b == 8'h20;
	endfunction

	function automatic logic digit_char(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
	endfunction

	function automatic logic [7:0] len_name_at(input int pos);
		return LEN_NAME[(13 - pos) * 8 +: 8];
	endfunction

	task automatic clear_line();
		phase = PH_LEAD;
		name_pos = 4'd0;
		name_ok = 1'b1;
		val_neg = 1'b0;
		val_acc = 31'd0;
	endtask

	task automatic clear_request();
		crlf_prog = 2'd0;
		hdr_seen = 1'b0;
		clear_line();
		len_val = 31'd0;
		len_seen = 1'b0;
		byte_cnt = 33'd0;
		target_cnt = COUNT_TOP;
		req_done = 1'b0;
		ovf_seen = 1'b0;
	endtask

	task automatic match_name(input logic [7:0] b);
		if (name_pos < hhlf_pkg::NAME_LEN && fold_case(b) == len_name_at(int'(name_pos)))
			name_pos = name_pos + 4'd1;
		else
			name_ok = 1'b0;
	endtask

	task automatic close_name();
		phase = (name_ok && name_pos == hhlf_pkg::NAME_LEN) ? PH_VLEAD : PH_SKIP;
	endtask

	task automatic take_digit(input logic [7:0] b);
		logic [63:0] v;
		v = 64'(val_acc);
		v = v * 64'd10 + {56'd0, b - 8'h30};
		if (v > 64'h7FFF_FFFF) begin
			v = 64'h7FFF_FFFF;
			if (!val_neg)
				ovf_seen = 1'b1;
		end
		val_acc = v[30:0];
		phase = PH_VDIGITS;
	endtask

	task automatic scan_char(input logic [7:0] b);
		logic sp;
		sp = space_char(b);
		case (phase)
			PH_LEAD: begin
				if (!sp) begin
					if (b == hhlf_pkg::CH_COLON) begin
						phase = PH_SKIP;
					end else begin
						phase = PH_NAME;
						match_name(b);
					end
				end
			end
			PH_NAME: begin
				if (b == hhlf_pkg::CH_COLON)
					close_name();
				else if (sp)
					phase = PH_TRAIL;
				else
					match_name(b);
			end
			PH_TRAIL: begin
				if (b == hhlf_pkg::CH_COLON) begin
					close_name();
				end else if (!sp) begin
					name_ok = 1'b0;
					phase = PH_NAME;
				end
			end
			PH_VLEAD: begin
				if (!sp) begin
					if (b == hhlf_pkg::CH_PLUS) begin
						phase = PH_VSIGN;
					end else if (b == hhlf_pkg::CH_MINUS) begin
						val_neg = 1'b1;
						phase = PH_VSIGN;
					end else if (digit_char(b)) begin
						take_digit(b);
					end else begin
						phase = PH_VDONE;
					end
				end
			end
			PH_VSIGN, PH_VDIGITS: begin
				if (digit_char(b))
					take_digit(b);
				else
					phase = PH_VDONE;
			end
			default: begin
			end
		endcase
	endtask

	task automatic end_line();
		if (phase >= PH_VLEAD && phase <= PH_VDONE) begin
			len_val = val_neg ? 31'd0 : val_acc;
			len_seen = 1'b1;
		end
		clear_line();
	endtask

	// Advances the predictor by one byte and returns the result it should produce.
	task automatic frame_byte(input logic [7:0] b, input logic fb, output frame_result_t r);
		logic was_cr;
		logic complete;
		logic [32:0] t;
		r.hend = 1'b0;
		complete = 1'b0;
		if (fb)
			clear_request();
		if (byte_cnt < COUNT_TOP)
			byte_cnt = byte_cnt + 33'd1;
		else
			ovf_seen = 1'b1;
		if (!hdr_seen) begin
			was_cr = crlf_prog[0];
			if (b == hhlf_pkg::CH_LF && was_cr)
				end_line();
			else
				scan_char(b);
			if (b == hhlf_pkg::CH_CR) begin
				crlf_prog = (crlf_prog == 2'd2) ? 2'd3 : 2'd1;
			end else if (b == hhlf_pkg::CH_LF) begin
				complete = (crlf_prog == 2'd3);
				crlf_prog = (crlf_prog == 2'd1) ? 2'd2 : 2'd0;
			end else begin
				crlf_prog = 2'd0;
			end
			if (complete) begin
				hdr_seen = 1'b1;
				r.hend = 1'b1;
				crlf_prog = 2'd0;
				if (len_seen) begin
					t = byte_cnt + {2'b00, len_val};
					if (t > COUNT_TOP) begin
						t = COUNT_TOP;
						ovf_seen = 1'b1;
					end
					target_cnt = t;
				end else begin
					req_done = 1'b1;
				end
			end
		end
		if (hdr_seen && len_seen && byte_cnt >= target_cnt)
			req_done = 1'b1;
		r.done = req_done;
		r.found = len_seen;
		r.len = len_val;
		r.seen = byte_cnt[31:0];
		r.ovf = ovf_seen;
	endtask

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// Request generation.
	task automatic push_byte(input logic [7:0] b);
		byte_item_t it;
		it.data = b;
		it.first = mark_first;
		mark_first = 1'b0;
		pending_bytes.push_back(it);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_blanks();
		int n;
		n = $urandom_range(0, 2);
		for (int i = 0; i < n; i++)
			push_byte($urandom_range(0, 1) ? 8'h20 : 8'h09);
	endtask

	// The header name in random case, now and then damaged so that it may fail to match.
	task automatic push_len_name();
		int damage;
		int pos;
		logic [7:0] c;
		damage = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0;
		pos = $urandom_range(0, 13);
		for (int i = 0; i < 14; i++) begin
			c = len_name_at(i);
			if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1))
				c = c - 8'd32;
			if (damage == 1 && i == pos)
				c = 8'h61 + 8'($urandom_range(0, 25));
			if (damage == 4 && i == pos && i != 0)
				push_byte(8'h20);
			if (!(damage == 2 && i == 13))
				push_byte(c);
		end
		if (damage == 3)
			push_byte("s");
	endtask

	task automatic push_len_value();
		int kind;
		int sgn;
		int n;
		kind = $urandom_range(0, 11);
		sgn = $urandom_range(0, 9);
		push_blanks();
		if (sgn == 0)
			push_byte(hhlf_pkg::CH_PLUS);
		else if (sgn == 1)
			push_byte(hhlf_pkg::CH_MINUS);
		case (kind)
			0, 1, 2, 3, 4, 5: begin
				if ($urandom_range(0, 5) == 0)
					push_byte("0");
				push_text($sformatf("%0d", $urandom_range(0, 24)));
			end
			6: begin
				case ($urandom_range(0, 2))
					0: push_text("2147483647");
					1: push_text("2147483648");
					default: begin
						n = $urandom_range(10, 14);
						push_byte(8'h31 + 8'($urandom_range(0, 8)));
						for (int i = 1; i < n; i++)
							push_byte(8'h30 + 8'($urandom_range(0, 9)));
					end
				endcase
			end
			7: begin
			end
			8: push_text("abc");
			9: push_text("7x9");
			10: begin
				// A lone CR or LF counts as whitespace and ends the digits.
				push_byte("1");
				push_byte($urandom_range(0, 1) ? hhlf_pkg::CH_CR : hhlf_pkg::CH_LF);
				push_byte("2");
			end
			default: push_text($sformatf("%0d", $urandom_range(0, 4000)));
		endcase
		push_blanks();
	endtask

	task automatic push_len_line();
		push_blanks();
		push_len_name();
		push_blanks();
		push_byte(hhlf_pkg::CH_COLON);
		push_len_value();
		push_text("\r\n");
	endtask

	task automatic push_other_line();
		int n;
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: push_text("Host: h.example\r\n");
			1: push_text(":12\r\n");
			2: push_text("X-Len 5\r\n");
			3: push_text("Content-Type: 4\r\n");
			default: begin
				n = $urandom_range(1, 10);
				for (int i = 0; i < n; i++) begin
					c = 8'($urandom_range(0, 255));
					if (c == hhlf_pkg::CH_CR || c == hhlf_pkg::CH_LF)
						c = 8'h80 | c;
					push_byte(c);
				end
				push_text("\r\n");
			end
		endcase
	endtask

	task automatic push_request();
		int shape;
		int lines;
		int body;
		mark_first = 1'b1;
		shape = $urandom_range(0, 13);
		if (shape == 0) begin
			// Pure noise over the whole byte range.
			body = $urandom_range(5, 30);
			for (int i = 0; i < body; i++)
				push_byte(8'($urandom_range(0, 255)));
		end else begin
			case ($urandom_range(0, 3))
				0: push_text("POST /f HTTP/1.0\r\n");
				1: begin
				end
				default: push_text("GET /a HTTP/1.1\r\n");
			endcase
			lines = $urandom_range(0, 3);
			for (int i = 0; i < lines; i++) begin
				if ($urandom_range(0, 2) != 0)
					push_len_line();
				else
					push_other_line();
			end
			if (shape == 1) begin
				// The header never ends; a value line is left open.
				push_blanks();
				push_len_name();
				push_byte(hhlf_pkg::CH_COLON);
				push_text("9");
			end else begin
				push_text("\r\n");
				body = $urandom_range(0, 3) == 0 ? $urandom_range(0, 30) : $urandom_range(0, 12);
				for (int i = 0; i < body; i++)
					push_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Sender: bursts of items separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		byte_item_t it;
		if (arst_n && (!in_valid || in_taken)) begin
			if (gap_left != 0 || pending_bytes.size() == 0) begin
				if (gap_left != 0)
					gap_left--;
				in_valid <= 1'b0;
			end else begin
				it = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= it.data;
				first_byte <= it.first;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
		end
	end

	// Receiver: free, light and heavy stall modes, plus one long hold-off.
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	logic hold_started = 1'b0;
	always @(negedge clk) begin
		if (!hold_started && bytes_in >= 300) begin
			hold_started = 1'b1;
			hold_left = 250;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(5, 60);
			end
			mode_left--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				default: out_stall <= ($urandom_range(0, 1) != 0);
			endcase
		end
	end

	// Input side feeds the predictor; output side checks against it.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				frame_byte(data_byte, first_byte, want);
				expected_frames.push_back(want);
				bytes_in++;
				if (first_byte)
					requests_in++;
			end
			if (out_valid && !out_stall) begin
				results_checked++;
				if (expected_frames.size() == 0) begin
					log_mismatch("result item with no expected frame waiting");
				end else begin
					want = expected_frames.pop_front();
					if (header_end != want.hend)
						log_mismatch($sformatf("header_end %0d, want %0d", header_end, want.hend));
					if (request_done != want.done)
						log_mismatch($sformatf("request_done %0d, want %0d",
							request_done, want.done));
					if (length_found != want.found)
						log_mismatch($sformatf("length_found %0d, want %0d",
							length_found, want.found));
					if (body_length != want.len)
						log_mismatch($sformatf("body_length %0d, want %0d", body_length, want.len));
					if (bytes_seen != want.seen)
						log_mismatch($sformatf("bytes_seen %0d, want %0d", bytes_seen, want.seen));
					if (length_overflow != want.ovf)
						log_mismatch($sformatf("length_overflow %0d, want %0d",
							length_overflow, want.ovf));
					header_ends += want.hend;
					done_results += want.done;
					ovf_results += want.ovf;
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end else begin
			in_taken <= 1'b0;
		end
	end

	initial begin
		wait (arst_n);
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		clear_request();
		// Short directed opening: extreme bytes relying on the reset state, then a
		// plain upper-case length line with a body that lands exactly on the end.
		push_byte(8'h00);
		push_byte(8'hFF);
		push_text("\r\n");
		mark_first = 1'b1;
		push_text("CONTENT-LENGTH:3\r\n\r\nabc");
		while (pending_bytes.size() < 1020)
			push_request();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("run covered %0d requests in %0d bytes, %0d results checked",
			requests_in, bytes_in, results_checked);
		$display("header ends %0d, done results %0d, overflow results %0d, mismatches %0d",
			header_ends, done_results, ovf_results, mismatches);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
